// ===== src/rtc_elapsed_time_advance_assert.svh =====
`ifndef RTC_ELAPSED_TIME_ADVANCE_ASSERT_SVH
`define RTC_ELAPSED_TIME_ADVANCE_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define RTCEA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtcea check failed");

// condition holds in the cycle after the trigger
`define RTCEA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtcea check failed");

`endif

// ===== src/rtcea_pkg.sv =====
`default_nettype none

package rtcea_pkg;

  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SECONDS_MASK = 3'd0,
    REG_MINUTES_MASK = 3'd1,
    REG_HOURS_MASK   = 3'd2,
    REG_DAY_MASK     = 3'd3,
    REG_MONTH_MASK   = 3'd4,
    REG_YEAR_MASK    = 3'd5,
    REG_WEEKDAY_MASK = 3'd6
  } reg_idx_t;

  // calendar constants
  localparam int SecPerMin     = 60;
  localparam int MinPerHour    = 60;
  localparam int HoursPerDay   = 24;
  localparam int DaysPerWeek   = 7;
  localparam int MonthsPerYear = 12;
  localparam int YearsPerCent  = 100;
  localparam int HoursHalfDay  = 12;
  localparam int FebDays       = 29;
  localparam int MaxHmsCarry   = 7;  // largest quotient in the minute and hour carries
  localparam int MaxDayCarry   = 5;  // largest month carry out of the day field

  // ms to seconds: drop three bits, then divide by 125 through a reciprocal
  localparam int MsPerSec      = 1000;
  localparam int MsPreShift    = 3;
  localparam int MsDivOdd      = MsPerSec >> MsPreShift;
  localparam int Recip125Shift = 28;
  localparam logic [21:0] Recip125 = 22'd2147483;

  localparam int Recip60Shift  = 21;
  localparam logic [15:0] Recip60 = 16'd34952;

  localparam int RecipSmallShift = 11;
  localparam logic [8:0] Recip7  = 9'd293;
  localparam logic [7:0] Recip12 = 8'd171;

  typedef struct packed {
    logic [7:0]  base_seconds_bcd;
    logic [7:0]  base_minutes_bcd;
    logic [7:0]  base_hours_bcd;
    logic [7:0]  base_day_bcd;
    logic [7:0]  base_month_bcd;
    logic [7:0]  base_year_bcd;
    logic [7:0]  base_weekday_bcd;
    logic [23:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [5:0] now_seconds;
    logic [5:0] now_minutes;
    logic [4:0] now_hours;
    logic [3:0] now_hours_twelve;
    logic       afternoon;
    logic [4:0] now_day;
    logic [3:0] now_month;
    logic [6:0] now_year;
    logic [2:0] now_weekday;
  } out_item_t;

  typedef struct packed {
    logic [7:0] seconds;
    logic [7:0] minutes;
    logic [7:0] hours;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;
    logic [7:0] weekday;
  } mask_set_t;

  localparam mask_set_t MaskRst = '{
    seconds: 8'h7F, minutes: 8'h7F, hours: 8'h3F, day: 8'h3F,
    month: 8'h1F, year: 8'hFF, weekday: 8'h07
  };

  // date side fields carried past the time-of-day carries
  typedef struct packed {
    logic [7:0] weekday;
    logic [7:0] day_idx;
    logic [7:0] mon_idx;
    logic [7:0] year;
    logic [4:0] month_len;
  } cal_ctx_t;

  typedef struct packed {
    logic [14:0] sec_total;
    logic [7:0]  minutes;
    logic [7:0]  hours;
    cal_ctx_t    ctx;
  } front_t;

  typedef struct packed {
    logic [5:0] n_sec;
    logic [5:0] n_min;
    logic [4:0] n_hr;
    logic [2:0] days;
    cal_ctx_t   ctx;
  } hms_t;

  function automatic logic [7:0] bcd_to_bin(input logic [7:0] raw, input logic [7:0] mask);
    logic [7:0] b;
    b = raw & mask;
    return 8'({b[7:4], 3'b000}) + 8'({b[7:4], 1'b0}) + 8'(b[3:0]);
  endfunction

  function automatic logic [4:0] month_days(input logic [7:0] m);
    logic odd;
    odd = (m > 8'd7) ? ~m[0] : m[0];
    if (m == 8'd2) begin
      return 5'(FebDays);
    end
    return odd ? 5'd31 : 5'd30;
  endfunction

endpackage

`default_nettype wire

// ===== src/rtcea_cfg.sv =====
`default_nettype none

module rtcea_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [rtcea_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [7:0]                         cfg_wdata,
  output rtcea_pkg::mask_set_t               masks
);
  import rtcea_pkg::*;

  mask_set_t masks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      masks_r <= MaskRst;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SECONDS_MASK: masks_r.seconds <= cfg_wdata;
        REG_MINUTES_MASK: masks_r.minutes <= cfg_wdata;
        REG_HOURS_MASK:   masks_r.hours   <= cfg_wdata;
        REG_DAY_MASK:     masks_r.day     <= cfg_wdata;
        REG_MONTH_MASK:   masks_r.month   <= cfg_wdata;
        REG_YEAR_MASK:    masks_r.year    <= cfg_wdata;
        REG_WEEKDAY_MASK: masks_r.weekday <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign masks = masks_r;

endmodule

`default_nettype wire

// ===== src/rtcea_front.sv =====
`default_nettype none

module rtcea_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_stall,
  input  rtcea_pkg::in_item_t   up_data,
  input  rtcea_pkg::mask_set_t  masks,
  output logic                  dn_valid,
  input  logic                  dn_stall,
  output rtcea_pkg::front_t     dn_data
);
  import rtcea_pkg::*;

  localparam int MsDivW = 24 - MsPreShift;
  localparam int ProdW  = MsDivW + 22;
  localparam int QmsW   = 15;

  typedef struct packed {
    logic [QmsW-1:0]   q_est;
    logic [MsDivW-1:0] ms_div;
    logic [7:0]        seconds;
    logic [7:0]        minutes;
    logic [7:0]        hours;
    logic [7:0]        day;
    logic [7:0]        month;
    logic [7:0]        year;
    logic [7:0]        weekday;
  } dec_t;

  dec_t              s1_nxt, s1_r;
  front_t            s2_nxt, s2_r;
  logic              v1_r, v2_r;
  logic              st1, st2;
  logic [ProdW-1:0]  prod125;
  logic [MsDivW-1:0] rem;
  logic [QmsW-1:0]   q_ms;

  assign st2      = v2_r && dn_stall;
  assign st1      = v1_r && st2;
  assign up_stall = st1;

  // stage 1: mask and decode, reciprocal multiply for the ms divide
  always_comb begin
    prod125        = ProdW'(up_data.elapsed_ms[23:MsPreShift]) * ProdW'(Recip125);
    s1_nxt.q_est   = prod125[Recip125Shift +: QmsW];
    s1_nxt.ms_div  = up_data.elapsed_ms[23:MsPreShift];
    s1_nxt.seconds = bcd_to_bin(up_data.base_seconds_bcd, masks.seconds);
    s1_nxt.minutes = bcd_to_bin(up_data.base_minutes_bcd, masks.minutes);
    s1_nxt.hours   = bcd_to_bin(up_data.base_hours_bcd, masks.hours);
    s1_nxt.day     = bcd_to_bin(up_data.base_day_bcd, masks.day);
    s1_nxt.month   = bcd_to_bin(up_data.base_month_bcd, masks.month);
    s1_nxt.year    = bcd_to_bin(up_data.base_year_bcd, masks.year);
    s1_nxt.weekday = bcd_to_bin(up_data.base_weekday_bcd, masks.weekday);
  end

  // stage 2: fix the quotient estimate (off by at most one), add base seconds
  always_comb begin
    rem  = s1_r.ms_div - MsDivW'(s1_r.q_est) * MsDivW'(MsDivOdd);
    q_ms = s1_r.q_est + QmsW'(rem >= MsDivW'(MsDivOdd));
    s2_nxt.sec_total     = q_ms + QmsW'(s1_r.seconds);
    s2_nxt.minutes       = s1_r.minutes;
    s2_nxt.hours         = s1_r.hours;
    s2_nxt.ctx.weekday   = s1_r.weekday;
    s2_nxt.ctx.day_idx   = (s1_r.day == 8'd0) ? 8'd0 : s1_r.day - 8'd1;
    s2_nxt.ctx.mon_idx   = (s1_r.month == 8'd0) ? 8'd0 : s1_r.month - 8'd1;
    s2_nxt.ctx.year      = s1_r.year;
    s2_nxt.ctx.month_len = month_days(s1_r.month);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (!st1) v1_r <= up_valid;
      if (!st2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!st1) s1_r <= s1_nxt;
    if (!st2) s2_r <= s2_nxt;
  end

  assign dn_valid = v2_r;
  assign dn_data  = s2_r;

endmodule

`default_nettype wire

// ===== src/rtcea_hms.sv =====
`default_nettype none
`include "rtc_elapsed_time_advance_assert.svh"

module rtcea_hms (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_stall,
  input  rtcea_pkg::front_t  up_data,
  output logic               dn_valid,
  input  logic               dn_stall,
  output rtcea_pkg::hms_t    dn_data
);
  import rtcea_pkg::*;

  localparam int ProdW = 31;

  typedef struct packed {
    logic [14:0] sec_total;
    logic [8:0]  q_est;
    logic [7:0]  minutes;
    logic [7:0]  hours;
    cal_ctx_t    ctx;
  } c1_t;

  typedef struct packed {
    logic [5:0] n_sec;
    logic [8:0] t_min;
    logic [7:0] hours;
    cal_ctx_t   ctx;
  } c2_t;

  typedef struct packed {
    logic [5:0] n_sec;
    logic [5:0] n_min;
    logic [7:0] t_hr;
    cal_ctx_t   ctx;
  } c3_t;

  c1_t              c1_nxt, c1_r;
  c2_t              c2_nxt, c2_r;
  c3_t              c3_nxt, c3_r;
  hms_t             c4_nxt, c4_r;
  logic             v1_r, v2_r, v3_r, v4_r;
  logic             st1, st2, st3, st4;
  logic [ProdW-1:0] prod60;
  logic [14:0]      r_sec;
  logic [8:0]       q_sec;
  logic [2:0]       q_min, q_hr;
  logic [8:0]       r_min;
  logic [7:0]       r_hr;

  assign st4      = v4_r && dn_stall;
  assign st3      = v3_r && st4;
  assign st2      = v2_r && st3;
  assign st1      = v1_r && st2;
  assign up_stall = st1;

  // stage 1: estimate seconds / 60
  always_comb begin
    prod60           = ProdW'(up_data.sec_total) * ProdW'(Recip60);
    c1_nxt.q_est     = prod60[Recip60Shift +: 9];
    c1_nxt.sec_total = up_data.sec_total;
    c1_nxt.minutes   = up_data.minutes;
    c1_nxt.hours     = up_data.hours;
    c1_nxt.ctx       = up_data.ctx;
  end

  // stage 2: correct, split off seconds, add base minutes
  always_comb begin
    q_sec = c1_r.q_est;
    r_sec = c1_r.sec_total - 15'(c1_r.q_est) * 15'(SecPerMin);
    if (r_sec >= 15'(SecPerMin)) begin
      q_sec = c1_r.q_est + 9'd1;
      r_sec = r_sec - 15'(SecPerMin);
    end
    c2_nxt.n_sec = r_sec[5:0];
    c2_nxt.t_min = q_sec + 9'(c1_r.minutes);
    c2_nxt.hours = c1_r.hours;
    c2_nxt.ctx   = c1_r.ctx;
  end

  // stage 3: minutes carry, small quotient from parallel compares
  always_comb begin
    q_min = 3'd0;
    for (int k = 1; k <= MaxHmsCarry; k++) begin
      if (c2_r.t_min >= 9'(MinPerHour * k)) q_min = 3'(k);
    end
    r_min        = c2_r.t_min - 9'(q_min) * 9'(MinPerHour);
    c3_nxt.n_sec = c2_r.n_sec;
    c3_nxt.n_min = r_min[5:0];
    c3_nxt.t_hr  = 8'(q_min) + c2_r.hours;
    c3_nxt.ctx   = c2_r.ctx;
  end

  // stage 4: hours carry into whole days
  always_comb begin
    q_hr = 3'd0;
    for (int k = 1; k <= MaxHmsCarry; k++) begin
      if (c3_r.t_hr >= 8'(HoursPerDay * k)) q_hr = 3'(k);
    end
    r_hr         = c3_r.t_hr - 8'(q_hr) * 8'(HoursPerDay);
    c4_nxt.n_sec = c3_r.n_sec;
    c4_nxt.n_min = c3_r.n_min;
    c4_nxt.n_hr  = r_hr[4:0];
    c4_nxt.days  = q_hr;
    c4_nxt.ctx   = c3_r.ctx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (!st1) v1_r <= up_valid;
      if (!st2) v2_r <= v1_r;
      if (!st3) v3_r <= v2_r;
      if (!st4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!st1) c1_r <= c1_nxt;
    if (!st2) c2_r <= c2_nxt;
    if (!st3) c3_r <= c3_nxt;
    if (!st4) c4_r <= c4_nxt;
  end

  assign dn_valid = v4_r;
  assign dn_data  = c4_r;

  `RTCEA_ASSERT_IMPL(a_sec_range, clk, rst_n, v2_r, c2_r.n_sec < 6'(SecPerMin))
  `RTCEA_ASSERT_IMPL(a_hr_range, clk, rst_n, v4_r, c4_r.n_hr < 5'(HoursPerDay))
  `RTCEA_ASSERT_NEXT(a_out_hold, clk, rst_n, v4_r && dn_stall, v4_r && $stable(c4_r))

endmodule

`default_nettype wire

// ===== src/rtcea_cal.sv =====
`default_nettype none
`include "rtc_elapsed_time_advance_assert.svh"

module rtcea_cal (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_stall,
  input  rtcea_pkg::hms_t      up_data,
  output logic                 dn_valid,
  input  logic                 dn_stall,
  output rtcea_pkg::out_item_t dn_data
);
  import rtcea_pkg::*;

  typedef struct packed {
    logic [5:0] n_sec;
    logic [5:0] n_min;
    logic [4:0] n_hr;
    logic [3:0] hr12;
    logic       pm;
    logic [4:0] n_day;
    logic [2:0] n_wd;
    logic [7:0] mon_sum;
    logic [7:0] year;
  } a1_t;

  typedef struct packed {
    logic [5:0] n_sec;
    logic [5:0] n_min;
    logic [4:0] n_hr;
    logic [3:0] hr12;
    logic       pm;
    logic [4:0] n_day;
    logic [2:0] n_wd;
    logic [3:0] n_mon;
    logic [7:0] year_sum;
  } a2_t;

  a1_t        a1_nxt, a1_r;
  a2_t        a2_nxt, a2_r;
  out_item_t  o_nxt, o_r;
  logic       v1_r, v2_r, v3_r;
  logic       st1, st2, st3;
  logic [7:0] wx, td, r_wd, r_day, r_mon, hr_half;
  logic [4:0] q_wd;
  logic [2:0] q_day;
  logic [3:0] q_mon;
  logic [15:0] prod7, prod12;

  assign st3      = v3_r && dn_stall;
  assign st2      = v2_r && st3;
  assign st1      = v1_r && st2;
  assign up_stall = st1;

  // stage 1: weekday mod 7, day wrap by month length, 12-hour form
  always_comb begin
    wx    = up_data.ctx.weekday + 8'(DaysPerWeek - 1) + 8'(up_data.days);
    prod7 = 16'(wx) * 16'(Recip7);
    q_wd  = prod7[RecipSmallShift +: 5];
    r_wd  = wx - 8'(q_wd) * 8'(DaysPerWeek);

    td    = up_data.ctx.day_idx + 8'(up_data.days);
    q_day = 3'd0;
    for (int k = 1; k <= MaxDayCarry; k++) begin
      if (td >= 8'(up_data.ctx.month_len) * 8'(k)) q_day = 3'(k);
    end
    r_day = td - 8'(q_day) * 8'(up_data.ctx.month_len);

    a1_nxt.pm = (up_data.n_hr >= 5'(HoursHalfDay));
    hr_half   = a1_nxt.pm ? 8'(up_data.n_hr) - 8'(HoursHalfDay) : 8'(up_data.n_hr);
    a1_nxt.hr12    = (hr_half == 8'd0) ? 4'(HoursHalfDay) : hr_half[3:0];
    a1_nxt.n_sec   = up_data.n_sec;
    a1_nxt.n_min   = up_data.n_min;
    a1_nxt.n_hr    = up_data.n_hr;
    a1_nxt.n_day   = 5'(r_day + 8'd1);
    a1_nxt.n_wd    = r_wd[2:0];
    a1_nxt.mon_sum = up_data.ctx.mon_idx + 8'(q_day);
    a1_nxt.year    = up_data.ctx.year;
  end

  // stage 2: month wrap, carry into the year
  always_comb begin
    prod12          = 16'(a1_r.mon_sum) * 16'(Recip12);
    q_mon           = prod12[RecipSmallShift +: 4];
    r_mon           = a1_r.mon_sum - 8'(q_mon) * 8'(MonthsPerYear);
    a2_nxt.n_sec    = a1_r.n_sec;
    a2_nxt.n_min    = a1_r.n_min;
    a2_nxt.n_hr     = a1_r.n_hr;
    a2_nxt.hr12     = a1_r.hr12;
    a2_nxt.pm       = a1_r.pm;
    a2_nxt.n_day    = a1_r.n_day;
    a2_nxt.n_wd     = a1_r.n_wd;
    a2_nxt.n_mon    = 4'(r_mon + 8'd1);
    a2_nxt.year_sum = a1_r.year + 8'(q_mon);
  end

  // stage 3: year mod 100, output register
  always_comb begin
    o_nxt.now_seconds      = a2_r.n_sec;
    o_nxt.now_minutes      = a2_r.n_min;
    o_nxt.now_hours        = a2_r.n_hr;
    o_nxt.now_hours_twelve = a2_r.hr12;
    o_nxt.afternoon        = a2_r.pm;
    o_nxt.now_day          = a2_r.n_day;
    o_nxt.now_month        = a2_r.n_mon;
    o_nxt.now_year         = (a2_r.year_sum >= 8'(YearsPerCent))
                             ? 7'(a2_r.year_sum - 8'(YearsPerCent))
                             : a2_r.year_sum[6:0];
    o_nxt.now_weekday      = a2_r.n_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (!st1) v1_r <= up_valid;
      if (!st2) v2_r <= v1_r;
      if (!st3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!st1) a1_r <= a1_nxt;
    if (!st2) a2_r <= a2_nxt;
    if (!st3) o_r  <= o_nxt;
  end

  assign dn_valid = v3_r;
  assign dn_data  = o_r;

  `RTCEA_ASSERT_IMPL(a_wd_range, clk, rst_n, v1_r, a1_r.n_wd < 3'(DaysPerWeek))
  `RTCEA_ASSERT_IMPL(a_date_range, clk, rst_n, v3_r, o_r.now_day != 5'd0 && o_r.now_month != 4'd0 && o_r.now_month <= 4'(MonthsPerYear) && o_r.now_year < 7'(YearsPerCent))
  `RTCEA_ASSERT_NEXT(a_no_drop, clk, rst_n, v1_r && !st1, v2_r)

endmodule

`default_nettype wire

// ===== src/rtc_elapsed_time_advance.sv =====
// channel   | ports                          | direction | transaction
// ----------+--------------------------------+-----------+-----------------------------------
// input     | in_valid, in_stall, in_data    | in        | register snapshot + elapsed ms
// result    | out_valid, out_stall, out_data | out       | current time and date
// config    | cfg_we, cfg_index, cfg_wdata   | in        | one mask register write
//
// one transaction in per cycle while in_stall is low; each passes through all stages to out_valid
// (2 front stages, 4 time-of-day stages, 3 calendar stages)
// the longest stage is the ms reciprocal multiply, 21 x 22 bits
// rst_n is synchronous: clears all valid bits, loads the mask reset values
// each stage holds while its successor is full and stalled, so bubbles collapse
// and in_stall rises only when the whole pipe is full behind a stalled output
`default_nettype none

module rtc_elapsed_time_advance (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rtcea_pkg::in_item_t           in_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output rtcea_pkg::out_item_t          out_data,
  // configuration port
  input  logic                          cfg_we,
  input  logic [rtcea_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [7:0]                    cfg_wdata
);
  import rtcea_pkg::*;

  mask_set_t masks;     // current BCD masks, applied in the first stage
  front_t    front_d;   // total seconds plus decoded date fields
  hms_t      hms_d;     // time of day and whole days carried
  logic      front_v, front_st;
  logic      hms_v, hms_st;

  // mask registers; the user writes them only while the pipe is empty, not enforced here
  rtcea_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .masks     (masks)
  );

  // bcd decode and elapsed ms to whole seconds
  rtcea_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_data  (in_data),
    .masks    (masks),
    .dn_valid (front_v),
    .dn_stall (front_st),
    .dn_data  (front_d)
  );

  // seconds, minutes, hours carry chain
  rtcea_hms u_hms (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (front_v),
    .up_stall (front_st),
    .up_data  (front_d),
    .dn_valid (hms_v),
    .dn_stall (hms_st),
    .dn_data  (hms_d)
  );

  // weekday, day, month, year and 12-hour form; owns the output register
  rtcea_cal u_cal (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (hms_v),
    .up_stall (hms_st),
    .up_data  (hms_d),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .dn_data  (out_data)
  );

endmodule

`default_nettype wire
